// ===== design/pcx_rle_row_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// PCX RLE row encoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_ROW_ENCODER_CORE_MACROS_SVH
`define PCX_RLE_ROW_ENCODER_CORE_MACROS_SVH

// Same-cycle implication.
`define PCXRLE_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define PCXRLE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/pcxrle_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX RLE package
// Run records and the command word passed from front end to back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pcxrle_pkg;

  localparam logic [5:0] MaxRun     = 6'd63;
  localparam logic [7:0] RunMark    = 8'hC0;
  localparam logic [7:0] EscapeByte = 8'hC1;

  // One run to be sent: value and length (1..63).
  typedef struct packed {
    logic [7:0] value;
    logic [5:0] len;
  } run_t;

  // Runs released by one pixel, packed from slot 0 up.
  typedef struct packed {
    run_t [2:0] runs;
    logic [1:0] n_runs;   // 1..3
    logic       row_end;  // last run closes the row
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/pcxrle_cmdq.sv =====
// ----------------------------------------------------------------------------
// PCX RLE command queue
// Small flop FIFO of run commands between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_cmdq
  import pcxrle_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  wire  pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/pcxrle_front.sv =====
// ----------------------------------------------------------------------------
// PCX RLE front end
// Tracks the open run and row column, turns each pixel into run commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_front
  import pcxrle_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [15:0] row_width_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] pixel
  input  wire         q_full_i,
  output logic        push_o,
  output cmd_t        push_cmd_o
);

  logic [7:0]  run_value_q, run_value_d;
  logic [5:0]  run_len_q, run_len_d;
  logic [15:0] column_q, column_d;

  logic        accept;
  logic        extend, extend_pad;
  logic [7:0]  add_value;
  logic [5:0]  add_len;
  logic [16:0] count, eff_width;
  logic        row_end, odd;
  logic        r0_vld, r1_vld;
  run_t        run0, run1, run2;
  cmd_t        cmd;
  logic [1:0]  n;

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // pixel joins the open run or starts a new one
    extend = (run_len_q != '0) && (s_axis_tdata == run_value_q) && (run_len_q < MaxRun);
    r0_vld = !extend && (run_len_q != '0);
    run0   = '{value: run_value_q, len: run_len_q};
    if (extend) begin
      add_value = run_value_q;
      add_len   = run_len_q + 6'd1;
    end else begin
      add_value = s_axis_tdata;
      add_len   = 6'd1;
    end

    count     = {1'b0, column_q} + 17'd1;
    eff_width = (row_width_i == '0) ? 17'h10000 : {1'b0, row_width_i};
    row_end   = (count >= eff_width);
    odd       = count[0];

    // zero pad byte on odd rows
    extend_pad = (add_value == 8'h00) && (add_len < MaxRun);
    r1_vld     = row_end && odd && !extend_pad;
    run1       = '{value: add_value, len: add_len};
    if (!odd) begin
      run2 = '{value: add_value, len: add_len};
    end else if (extend_pad) begin
      run2 = '{value: add_value, len: add_len + 6'd1};
    end else begin
      run2 = '{value: 8'h00, len: 6'd1};
    end

    cmd  = '0;
    n    = '0;
    if (r0_vld) begin
      cmd.runs[n] = run0;
      n = n + 2'd1;
    end
    if (r1_vld) begin
      cmd.runs[n] = run1;
      n = n + 2'd1;
    end
    if (row_end) begin
      cmd.runs[n] = run2;
      n = n + 2'd1;
    end
    cmd.n_runs  = n;
    cmd.row_end = row_end;

    push_o     = accept && (n != '0);
    push_cmd_o = cmd;

    run_value_d = run_value_q;
    run_len_d   = run_len_q;
    column_d    = column_q;
    if (accept) begin
      run_value_d = add_value;
      run_len_d   = row_end ? 6'd0 : add_len;
      column_d    = row_end ? 16'd0 : count[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q <= '0;
      run_len_q   <= '0;
      column_q    <= '0;
    end else begin
      run_value_q <= run_value_d;
      run_len_q   <= run_len_d;
      column_q    <= column_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pcxrle_back.sv =====
// ----------------------------------------------------------------------------
// PCX RLE back end
// Expands queued run commands into coded bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_back
  import pcxrle_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cmd_t       head_i,
  input  wire        q_empty_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // row_done
  output logic       m_axis_tuser    // [0] last_of_batch
);

  logic [1:0] ri_q, ri_d;
  logic       ph_q, ph_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q, row_q;

  run_t       cur;
  logic       two_byte, run_end, cmd_end, advance;
  logic [7:0] first_byte, next_byte;

  always_comb begin
    cur      = head_i.runs[ri_q];
    two_byte = (cur.len > 6'd1) || (cur.value >= RunMark);
    if (cur.len > 6'd1) begin
      first_byte = RunMark | {2'b00, cur.len};
    end else if (cur.value >= RunMark) begin
      first_byte = EscapeByte;
    end else begin
      first_byte = cur.value;
    end
    next_byte = ph_q ? cur.value : first_byte;
    run_end   = two_byte ? ph_q : 1'b1;
    cmd_end   = run_end && (ri_q == head_i.n_runs - 2'd1);
    advance   = !q_empty_i && (!valid_q || m_axis_tready);
    pop_o     = advance && cmd_end;

    ri_d = ri_q;
    ph_d = ph_q;
    if (advance) begin
      if (cmd_end) begin
        ri_d = '0;
        ph_d = 1'b0;
      end else if (run_end) begin
        ri_d = ri_q + 2'd1;
        ph_d = 1'b0;
      end else begin
        ph_d = 1'b1;
      end
    end

    if (advance) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q    <= '0;
      ph_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      ri_q    <= ri_d;
      ph_q    <= ph_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= next_byte;
      last_q <= cmd_end;
      row_q  <= cmd_end && head_i.row_end;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = byte_q;
  assign m_axis_tuser  = last_q;
  assign m_axis_tlast  = row_q;

endmodule

`default_nettype wire

// ===== design/pcx_rle_row_encoder_core.sv =====
// ----------------------------------------------------------------------------
// PCX RLE row encoder core
// Streams 8-bit pixels in and PCX run-length coded row bytes out.
// ----------------------------------------------------------------------------
// Usage: pixels arrive one per transaction on the slave stream; coded bytes
// leave one per transaction on the master stream, tuser marking the final
// byte released by a pixel and tlast the final byte of a row. Rows are
// row_width pixels (0 means 65536) and odd rows get one zero pad byte. The
// front end takes a pixel every cycle while its command queue has room; the
// back end writes one coded byte per cycle to the output register unless the
// output stalls; a pixel yields 0 to 5 bytes. The back end's single byte-wide
// output register sets the sustained rate. The user writes row_width through
// cfg_we_i / cfg_wdata_i while the block idles; the block does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_row_encoder_core
  import pcxrle_pkg::*;
#(
  parameter int unsigned QueueDepth = 4   // run commands in flight, >= 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration: row_width
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  // pixel stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] pixel
  // coded byte stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // row_done
  output logic        m_axis_tuser    // [0] last_of_batch
);

  logic [15:0] row_width_q;

  // front end -> queue
  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  // queue -> back end
  cmd_t        head;
  logic        q_empty;
  logic        pop;

  // Row width register; no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= 16'd320;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  // Front: run tracking, row counting and pad insertion.
  pcxrle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_width_i   (row_width_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  // Decouples pixel intake from byte output.
  pcxrle_cmdq #(
    .Depth (QueueDepth)
  ) u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty)
  );

  // Back: byte coding (mark + value, escape + value, or plain value).
  pcxrle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== design/pcxrle_checker.sv =====
// ----------------------------------------------------------------------------
// PCX RLE port checker
// Port-level assertions on the coded byte stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcx_rle_row_encoder_core_macros.svh"

module pcxrle_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata,
  input wire       m_axis_tlast,
  input wire       m_axis_tuser
);

  // stalled output transaction holds
  `PCXRLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output changed while stalled")

  // end of row is always the end of a pixel's bytes
  `PCXRLE_ASSERT(a_row_is_batch_end, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "row end without batch end")

  // within a batch the back end delivers bytes without gaps
  `PCXRLE_ASSERT_NEXT(a_batch_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tuser, m_axis_tvalid, "gap inside batch")

endmodule

bind pcx_rle_row_encoder_core pcxrle_checker u_checker (.*);

`default_nettype wire
